### sv/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and constants for the indexed insert/delete list: request and
// status codes, field widths and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package iidl_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CAP_W     = 7;
	localparam int unsigned ST_W      = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND    = 3'd0,
		REQ_INSERT    = 3'd1,
		REQ_DELETE    = 3'd2,
		REQ_OVERWRITE = 3'd3,
		REQ_READ      = 3'd4,
		REQ_CLEAR     = 3'd5
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;         // latch the request
		logic    set_result;   // load status and default read data
		status_t st;
		logic    rd_bad;       // read data of all ones
		logic    wr_word_end;  // write word at slot count
		logic    wr_word_pos;  // write word at slot position
		logic    shift_start;  // set pointer, issue first move read
		logic    shift_step;   // move one entry, issue the next read
		logic    rd_pos;       // issue read at position
		logic    rd_take;      // capture read data into result
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t req;
		logic range_err;
		logic full_err;
		logic at_end;      // no entries to move
		logic shift_last;  // current move is the final one
	} dp_stat_t;

endpackage

### sv/indexed_insert_delete_list.sv
// Steps: latch, decide in S_DECIDE, answer in S_RESP; a read adds S_RDWAIT, an
//   insert adds S_SHIFT and S_FINAL to move m = count-pos entries, a delete adds
//   S_SHIFT for count-1-pos. start is ignored while busy; busy falls after done.
// Entries move one per cycle through the single write port of the entry store.
// The receiver cannot stall; status and read_word hold until the next decision.
// Reset: count cleared and capacity_limit set to 64 at once; store not cleared.
module indexed_insert_delete_list import iidl_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic        [REQ_W-1:0]  req_type,
	input  logic        [POS_W-1:0]  position,
	input  logic signed [WORD_W-1:0] word_in,
	output logic                     done,
	output logic        [ST_W-1:0]   status,
	output logic signed [WORD_W-1:0] read_word,
	output logic        [CW-1:0]     element_count,
	input  logic                     cfg_wr_en,
	input  logic        [CAP_W-1:0]  cfg_wr_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	iidl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	iidl_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req_type      (req_type),
		.position      (position),
		.word_in       (word_in),
		.status        (status),
		.read_word     (read_word),
		.element_count (element_count)
	);

endmodule

### sv/iidl_ctrl.sv
// ----------------------------------------------------------------------------
// iidl_ctrl
// Request sequencer: decodes the latched request, steps the entry moves for
// insert and delete one per cycle, and strobes the result.
// ----------------------------------------------------------------------------
module iidl_ctrl import iidl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SHIFT  = 6'b000100,
		S_FINAL  = 6'b001000,
		S_RDWAIT = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

	always_comb begin
		cmd       = '0;
		cmd.st    = ST_DONE;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.set_result = 1'b1;
				state_nxt      = S_RESP;
				case (stat.req)
					REQ_APPEND: begin
						if (stat.full_err) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.wr_word_end = 1'b1;
							cmd.cnt_inc     = 1'b1;
						end
					end
					REQ_INSERT: begin
						// position check comes before the full check
						if (stat.range_err) begin
							cmd.st = ST_RANGE;
						end else if (stat.full_err) begin
							cmd.st = ST_FULL;
						end else if (stat.at_end) begin
							cmd.wr_word_pos = 1'b1;
							cmd.cnt_inc     = 1'b1;
						end else begin
							cmd.shift_start = 1'b1;
							state_nxt       = S_SHIFT;
						end
					end
					REQ_DELETE: begin
						if (stat.range_err) begin
							cmd.st = ST_RANGE;
						end else if (stat.at_end) begin
							cmd.cnt_dec = 1'b1;
						end else begin
							cmd.shift_start = 1'b1;
							state_nxt       = S_SHIFT;
						end
					end
					REQ_OVERWRITE: begin
						if (stat.range_err) begin
							cmd.st = ST_RANGE;
						end else begin
							cmd.wr_word_pos = 1'b1;
						end
					end
					REQ_READ: begin
						if (stat.range_err) begin
							cmd.st     = ST_RANGE;
							cmd.rd_bad = 1'b1;
						end else begin
							cmd.rd_pos = 1'b1;
							state_nxt  = S_RDWAIT;
						end
					end
					REQ_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					if (stat.req == REQ_INSERT) begin
						state_nxt = S_FINAL;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_nxt   = S_RESP;
					end
				end
			end
			S_FINAL: begin
				cmd.wr_word_pos = 1'b1;
				cmd.cnt_inc     = 1'b1;
				state_nxt       = S_RESP;
			end
			S_RDWAIT: begin
				cmd.rd_take = 1'b1;
				state_nxt   = S_RESP;
			end
			S_RESP: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for two cycles");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("request not taken up");

endmodule

### sv/iidl_dpath.sv
// ----------------------------------------------------------------------------
// iidl_dpath
// Entry store, element count, capacity register, request latch and result
// registers. Entries move through the single write port one per cycle.
// ----------------------------------------------------------------------------
module iidl_dpath import iidl_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic                     cfg_wr_en,
	input  logic        [CAP_W-1:0]  cfg_wr_data,
	input  logic        [REQ_W-1:0]  req_type,
	input  logic        [POS_W-1:0]  position,
	input  logic signed [WORD_W-1:0] word_in,
	output logic        [ST_W-1:0]   status,
	output logic signed [WORD_W-1:0] read_word,
	output logic        [CW-1:0]     element_count
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rdata_q;

	req_t                     req_q;
	logic        [POS_W-1:0]  pos_q;
	logic signed [WORD_W-1:0] word_q;
	logic        [AW-1:0]     ptr_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] read_word_q;
	logic        [CW-1:0]     count_q;
	logic        [CAP_W-1:0]  cap_q;

	logic [CMPW-1:0] pos_x, cnt_x, ptr_x, cap_x, eff_cap;
	logic [CMPW-1:0] cnt_m1, pos_p1, ptr_m2, ptr_p2, ptr_m1, ptr_p1;
	logic            ins;

	logic                     we, re;
	logic        [AW-1:0]     waddr, raddr;
	logic signed [WORD_W-1:0] wdata;

	assign pos_x = CMPW'(pos_q);
	assign cnt_x = CMPW'(count_q);
	assign ptr_x = CMPW'(ptr_q);
	assign cap_x = CMPW'(cap_q);

	assign cnt_m1 = cnt_x - CMPW'(1);
	assign pos_p1 = pos_x + CMPW'(1);
	assign ptr_m1 = ptr_x - CMPW'(1);
	assign ptr_p1 = ptr_x + CMPW'(1);
	assign ptr_m2 = ptr_x - CMPW'(2);
	assign ptr_p2 = ptr_x + CMPW'(2);

	assign ins = (req_q == REQ_INSERT);

	// capacity clamped to 1..DEPTH
	always_comb begin
		if (cap_x == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_x > CMPW'(DEPTH)) begin
			eff_cap = CMPW'(DEPTH);
		end else begin
			eff_cap = cap_x;
		end
	end

	always_comb begin
		stat.req        = req_q;
		stat.range_err  = ins ? (pos_x > cnt_x) : (pos_x >= cnt_x);
		stat.full_err   = (cnt_x >= eff_cap);
		stat.at_end     = ins ? (pos_x == cnt_x) : (pos_p1 == cnt_x);
		// insert moves downwards to pos+1, delete upwards to count-2
		stat.shift_last = ins ? (ptr_x == pos_p1) : (ptr_p2 == cnt_x);
	end

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = word_q;
		re    = 1'b0;
		raddr = pos_x[AW-1:0];
		if (cmd.wr_word_end) begin
			we    = 1'b1;
			waddr = cnt_x[AW-1:0];
		end
		if (cmd.wr_word_pos) begin
			we    = 1'b1;
			waddr = pos_x[AW-1:0];
		end
		if (cmd.shift_start) begin
			re    = 1'b1;
			raddr = ins ? cnt_m1[AW-1:0] : pos_p1[AW-1:0];
		end
		if (cmd.shift_step) begin
			we    = 1'b1;
			waddr = ptr_q;
			wdata = rdata_q;
			if (!stat.shift_last) begin
				re    = 1'b1;
				raddr = ins ? ptr_m2[AW-1:0] : ptr_p2[AW-1:0];
			end
		end
		if (cmd.rd_pos) begin
			re    = 1'b1;
			raddr = pos_x[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_t'(req_type);
			pos_q  <= position;
			word_q <= word_in;
		end
		if (cmd.shift_start) begin
			ptr_q <= ins ? cnt_x[AW-1:0] : pos_x[AW-1:0];
		end else if (cmd.shift_step && !stat.shift_last) begin
			ptr_q <= ins ? ptr_m1[AW-1:0] : ptr_p1[AW-1:0];
		end
		if (cmd.set_result) begin
			status_q    <= cmd.st;
			read_word_q <= cmd.rd_bad ? '1 : '0;
		end else if (cmd.rd_take) begin
			read_word_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign status        = status_q;
	assign read_word     = read_word_q;
	assign element_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= CMPW'(DEPTH)) else $error("element count beyond store depth");

	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cnt_x < eff_cap)) else $error("count raised on a full list");

	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (count_q != '0)) else $error("count lowered on an empty list");

endmodule

### sim/iidl_list_checker.sv
// ----------------------------------------------------------------------------
// iidl_list_checker
// Watches the request, result and capacity ports of the indexed list, keeps
// its own copy of the list contents, queues the reply due for each accepted
// request and compares every result strobe with the oldest reply due.
// ----------------------------------------------------------------------------
module iidl_list_checker import iidl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic        [REQ_W-1:0]  req_type,
	input  logic        [POS_W-1:0]  position,
	input  logic signed [WORD_W-1:0] word_in,
	input  logic                     done,
	input  logic        [ST_W-1:0]   status,
	input  logic signed [WORD_W-1:0] read_word,
	input  logic        [CAP_W-1:0]  element_count,
	input  logic                     cfg_wr_en,
	input  logic        [CAP_W-1:0]  cfg_wr_data,
	output int                       pending,
	output int                       mismatches,
	output logic        [CAP_W-1:0]  held
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t                  st;
		logic signed [WORD_W-1:0] word;
		logic        [CAP_W-1:0]  len;
	} list_reply_t;

	logic signed [WORD_W-1:0] shadow_words [DEPTH_DEF];
	int unsigned              shadow_len;
	logic        [CAP_W-1:0]  shadow_cap;
	list_reply_t              replies_due [$];
	int unsigned              errs = 0;
	int unsigned              reply_no = 0;

	assign mismatches = errs;

	task automatic note_mismatch(string msg);
		errs++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// capacity register clamped to 1..DEPTH
	function automatic int unsigned room();
		int unsigned c;
		c = shadow_cap;
		if (c < 1)
			c = 1;
		if (c > DEPTH_DEF)
			c = DEPTH_DEF;
		return c;
	endfunction

	function automatic list_reply_t apply_request(logic [REQ_W-1:0] code,
			logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] w);
		list_reply_t r;
		int unsigned p;
		int unsigned i;
		r.st   = ST_DONE;
		r.word = '0;
		p      = pos;
		case (code)
			REQ_APPEND: begin
				if (shadow_len >= room()) begin
					r.st = ST_FULL;
				end else begin
					shadow_words[shadow_len] = w;
					shadow_len++;
				end
			end
			REQ_INSERT: begin
				// range is checked ahead of full
				if (p > shadow_len) begin
					r.st = ST_RANGE;
				end else if (shadow_len >= room()) begin
					r.st = ST_FULL;
				end else begin
					for (i = shadow_len; i > p; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[p] = w;
					shadow_len++;
				end
			end
			REQ_DELETE: begin
				if (p >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = p; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
				end
			end
			REQ_OVERWRITE: begin
				if (p >= shadow_len)
					r.st = ST_RANGE;
				else
					shadow_words[p] = w;
			end
			REQ_READ: begin
				if (p >= shadow_len) begin
					r.st   = ST_RANGE;
					r.word = -1;
				end else begin
					r.word = shadow_words[p];
				end
			end
			REQ_CLEAR: shadow_len = 0;
			default: ;
		endcase
		r.len = CAP_W'(shadow_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t due;
		if (!arst_n) begin
			replies_due.delete();
			shadow_len = 0;
			shadow_cap = CAP_RESET;
			pending <= 0;
			held    <= '0;
		end else begin
			// retire first: a strobe belongs to an older request
			if (done) begin
				reply_no++;
				if (replies_due.size() == 0) begin
					note_mismatch($sformatf("result %0d with no request outstanding",
						reply_no));
				end else begin
					due = replies_due.pop_front();
					if (status !== due.st)
						note_mismatch($sformatf("result %0d status %0d, want %0d",
							reply_no, status, due.st));
					if (read_word !== due.word)
						note_mismatch($sformatf("result %0d read_word %0h, want %0h",
							reply_no, read_word, due.word));
					if (element_count !== due.len)
						note_mismatch($sformatf("result %0d element_count %0d, want %0d",
							reply_no, element_count, due.len));
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_request(req_type, position, word_in));
			if (cfg_wr_en)
				shadow_cap = cfg_wr_data;
			pending <= replies_due.size();
			held    <= CAP_W'(shadow_len);
		end
	end

endmodule

### sim/indexed_insert_delete_list_tb.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_tb
// Drives directed and random request streams into the indexed list under
// several capacity settings and sender gap rates; the checker beside the
// block predicts and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iidl_pkg::*;

	localparam int unsigned RUN_LIMIT = 600000;
	localparam int unsigned SETTLE    = 80;

	// request codes the block leaves unused
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     start       = 1'b0;
	logic        [REQ_W-1:0]  req_type    = '0;
	logic        [POS_W-1:0]  position    = '0;
	logic signed [WORD_W-1:0] word_in     = '0;
	logic                     cfg_wr_en   = 1'b0;
	logic        [CAP_W-1:0]  cfg_wr_data = '0;

	logic                     busy;
	logic                     done;
	logic        [ST_W-1:0]   status;
	logic signed [WORD_W-1:0] read_word;
	logic        [CAP_W-1:0]  element_count;

	int                       pending;
	int                       mismatches;
	logic        [CAP_W-1:0]  held;
	int unsigned              cycles  = 0;
	int unsigned              gap_pct = 0;

	indexed_insert_delete_list DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.position      (position),
		.word_in       (word_in),
		.done          (done),
		.status        (status),
		.read_word     (read_word),
		.element_count (element_count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	iidl_list_checker list_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.position      (position),
		.word_in       (word_in),
		.done          (done),
		.status        (status),
		.read_word     (read_word),
		.element_count (element_count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.pending       (pending),
		.mismatches    (mismatches),
		.held          (held)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// returns at the edge that takes the request
	task automatic push_request(logic [REQ_W-1:0] code, logic [POS_W-1:0] pos,
			logic [WORD_W-1:0] w);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		req_type <= code;
		position <= pos;
		word_in  <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] v);
		wait_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// held lags by a request or so; good enough to steer positions
	function automatic logic [POS_W-1:0] pick_pos(bit for_insert, bit stray);
		int unsigned lo_bad;
		int unsigned hi_ok;
		lo_bad = for_insert ? held + 1 : held;
		if (stray && lo_bad <= 63)
			return POS_W'($urandom_range(63, lo_bad));
		if (for_insert)
			hi_ok = held;
		else
			hi_ok = (held == 0) ? 0 : held - 1;
		if (hi_ok > 63)
			hi_ok = 63;
		return POS_W'($urandom_range(hi_ok, 0));
	endfunction

	task automatic one_op();
		logic [REQ_W-1:0] code;
		int unsigned      r;
		bit               stray;
		stray = ($urandom_range(9) < 2);
		r     = $urandom_range(99);
		if (r < 20)
			code = REQ_APPEND;
		else if (r < 40)
			code = REQ_INSERT;
		else if (r < 55)
			code = REQ_DELETE;
		else if (r < 70)
			code = REQ_OVERWRITE;
		else if (r < 93)
			code = REQ_READ;
		else if (r < 96)
			code = REQ_CLEAR;
		else if (r < 98)
			code = REQ_SPARE_A;
		else
			code = REQ_SPARE_B;
		push_request(code, pick_pos(code == REQ_INSERT, stray), pick_word());
	endtask

	task automatic random_phase(int unsigned quota);
		int unsigned sent;
		int unsigned burst;
		int unsigned k;
		sent = 0;
		while (sent < quota) begin
			case ($urandom_range(19))
				0, 1, 2: begin
					// fill towards the capacity
					burst = $urandom_range(40, 8);
					for (k = 0; k < burst; k++)
						push_request(REQ_APPEND, POS_W'($urandom()), pick_word());
				end
				3: begin
					burst = $urandom_range(12, 1);
					for (k = 0; k < burst; k++)
						push_request(REQ_DELETE, pick_pos(1'b0, 1'b0), pick_word());
				end
				4: begin
					// raw noise over every field
					burst = $urandom_range(6, 1);
					for (k = 0; k < burst; k++)
						push_request(REQ_W'($urandom()), POS_W'($urandom()), $urandom());
				end
				5: begin
					burst = 0;
					wait_quiet();
				end
				default: begin
					burst = $urandom_range(12, 4);
					for (k = 0; k < burst; k++)
						one_op();
				end
			endcase
			sent += burst;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_capacity(CAP_RESET);
		// empty list: read, delete, overwrite and insert at 1 out of range, then fill
		push_request(REQ_READ,      6'd0,  '0);
		push_request(REQ_DELETE,    6'd0,  '0);
		push_request(REQ_OVERWRITE, 6'd0,  32'h1234_5678);
		push_request(REQ_INSERT,    6'd1,  32'h1111_1111);
		push_request(REQ_INSERT,    6'd0,  32'h7FFF_FFFF);
		push_request(REQ_APPEND,    6'd63, 32'h8000_0000);
		push_request(REQ_APPEND,    6'd0,  32'hFFFF_FFFF);
		push_request(REQ_INSERT,    6'd3,  32'h0000_0000);
		push_request(REQ_INSERT,    6'd1,  32'h5555_5555);
		push_request(REQ_READ,      6'd4,  '0);
		push_request(REQ_OVERWRITE, 6'd2,  32'hAAAA_AAAA);
		push_request(REQ_READ,      6'd2,  '0);
		push_request(REQ_DELETE,    6'd0,  '0);
		push_request(REQ_DELETE,    6'd3,  '0);
		push_request(REQ_READ,      6'd3,  '0);
		push_request(REQ_READ,      6'd63, '1);
		push_request(REQ_SPARE_A,   6'd0,  32'hDEAD_BEEF);
		push_request(REQ_SPARE_B,   6'd63, '1);
		push_request(REQ_CLEAR,     6'd0,  '0);
		push_request(REQ_READ,      6'd0,  '0);

		// small capacity: full, then range taking priority over full
		set_capacity(7'd2);
		push_request(REQ_APPEND, 6'd0, 32'h0BAD_F00D);
		push_request(REQ_APPEND, 6'd0, 32'hC001_D00D);
		push_request(REQ_APPEND, 6'd0, 32'h0000_0001);
		push_request(REQ_INSERT, 6'd0, 32'h0000_0002);
		push_request(REQ_INSERT, 6'd5, 32'h0000_0003);

		// capacity lowered under the count: held entries stay usable
		set_capacity(7'd1);
		push_request(REQ_APPEND,    6'd0, 32'h0000_0004);
		push_request(REQ_OVERWRITE, 6'd1, 32'hFEED_FACE);
		push_request(REQ_READ,      6'd1, '0);
		push_request(REQ_CLEAR,     6'd0, '0);

		gap_pct = 0;
		set_capacity(7'd64);
		random_phase(190);
		gap_pct = 78;
		set_capacity(7'd16);
		random_phase(190);
		gap_pct = 21;
		set_capacity(7'd127);
		random_phase(190);
		gap_pct = 0;
		set_capacity(7'd0);
		random_phase(150);
		gap_pct = 78;
		set_capacity(7'd33);
		random_phase(190);
		gap_pct = 21;
		set_capacity(7'd64);
		random_phase(190);

		wait_quiet();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		wait (cycles >= RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
